@@ rtl/core/first_fit_block_allocator_macros.svh @@
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define FFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("first_fit_block_allocator: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define FFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("first_fit_block_allocator: next-cycle check failed");

`endif

@@ rtl/core/ffa_pkg.sv @@
`timescale 1ns / 1ps

package ffa_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int HEADER_BYTES = 24;
   localparam int HEAP_BYTES   = 65536;
   // growth bound: payload addresses must fit 16 bits
   localparam int LIMIT_CAP    = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_NOMEM   = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [16:0] request_size;
      logic [15:0] release_address;
   } ffa_req_type;

   typedef struct packed {
      logic [15:0] payload_address;
      logic [1:0]  status;
   } ffa_rsp_type;

   typedef struct packed {
      logic [15:0] start;
      logic [16:0] length;
      logic        is_free;
   } ffa_entry_type;

endpackage

@@ rtl/core/first_fit_block_allocator.sv @@
`timescale 1ns / 1ps
// First-fit block allocator over a 64-entry block table held in one memory.
// A zero-size allocate, a null free or a request on an empty table skips the
//   scan; others read the entries in order up to the first hit.
// Throughput: one request at a time; the next beat is taken once the result
//   is registered. The table scan (one memory read per cycle) sets the figure.
// Reset (synchronous, active high): table empty, heap top 0, limit 65536.

`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator
   import ffa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ffa_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ffa_rsp_type rsp_payload,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data
);

   // sequencer codes
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   // control state
   logic [1:0]       state_ff,       state_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [16:0]      heap_top_ff,    heap_top_in;
   logic [16:0]      heap_limit_ff,  heap_limit_in;
   logic             rsp_valid_ff,   rsp_valid_in;
   logic             chk_vld_ff,     chk_vld_in;

   // working registers of the current request
   ffa_req_type      req_ff,         req_in;
   logic [17:0]      total_ff,       total_in;
   logic [CNT_W-1:0] issue_idx_ff,   issue_idx_in;
   logic [CNT_W-1:0] chk_idx_ff,     chk_idx_in;
   logic             hit_ff,         hit_in;
   logic [CNT_W-1:0] hit_idx_ff,     hit_idx_in;
   ffa_entry_type    hit_entry_ff,   hit_entry_in;
   ffa_rsp_type      rsp_payload_ff, rsp_payload_in;

   // block table memory: one write port, one registered read port
   ffa_entry_type    entry_mem [MAX_BLOCKS];
   ffa_entry_type    rd_entry_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   ffa_entry_type    mem_wd;

   logic             req_fire;
   logic             apply_go;
   logic             ignore_req;
   logic             entry_hit;
   logic             last_checked;
   logic [16:0]      eff_limit;
   logic [18:0]      grow_top;
   logic [17:0]      hit_end;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // heap_limit above the cap acts as the cap
   assign eff_limit = (heap_limit_ff > 17'(LIMIT_CAP)) ? 17'(LIMIT_CAP) : heap_limit_ff;

   assign ignore_req = (req_ff.mode == MODE_ALLOC) ? (req_ff.request_size == 17'd0)
                                                   : (req_ff.release_address == 16'd0);

   // hit test on the entry that was read last cycle
   always_comb begin
      if (req_ff.mode == MODE_ALLOC) begin
         entry_hit = rd_entry_ff.is_free && (rd_entry_ff.length >= req_ff.request_size);
      end else begin
         entry_hit = (({1'b0, rd_entry_ff.start} + 17'(HEADER_BYTES))
                      == {1'b0, req_ff.release_address});
      end
   end

   assign last_checked = ((chk_idx_ff + CNT_W'(1)) == entry_count_ff);
   assign grow_top     = {2'b00, heap_top_ff} + {1'b0, total_ff};
   assign hit_end      = {2'b00, hit_entry_ff.start} + 18'(HEADER_BYTES)
                         + {1'b0, hit_entry_ff.length};

   // commit needs the result register free
   assign apply_go = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      heap_top_in    = heap_top_ff;
      heap_limit_in  = csr_wr_en ? csr_wr_data : heap_limit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      chk_vld_in     = 1'b0;
      req_in         = req_ff;
      total_in       = total_ff;
      issue_idx_in   = issue_idx_ff;
      chk_idx_in     = chk_idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_entry_in   = hit_entry_ff;
      rsp_payload_in = rsp_payload_ff;
      mem_we         = 1'b0;
      mem_wa         = '0;
      mem_wd         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // latch the beat, start the scan at entry 0
               req_in       = req_payload;
               total_in     = 18'(HEADER_BYTES) + {1'b0, req_payload.request_size};
               hit_in       = 1'b0;
               issue_idx_in = '0;
               if ((req_payload.mode == MODE_ALLOC) ? (req_payload.request_size == 17'd0)
                                                    : (req_payload.release_address == 16'd0))
               begin
                  state_in = S_APPLY;
               end else if (entry_count_ff == '0) begin
                  state_in = S_APPLY;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue the next read while the previous one is checked
            if (issue_idx_ff < entry_count_ff) begin
               chk_vld_in   = 1'b1;
               chk_idx_in   = issue_idx_ff;
               issue_idx_in = issue_idx_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               if (entry_hit) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = chk_idx_ff;
                  hit_entry_in = rd_entry_ff;
                  chk_vld_in   = 1'b0;
                  state_in     = S_APPLY;
               end else if (last_checked) begin
                  chk_vld_in = 1'b0;
                  state_in   = S_APPLY;
               end
            end
         end
         S_APPLY: begin
            if (apply_go) begin
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
               rsp_payload_in = '{payload_address: 16'd0, status: STATUS_DONE};
               priority if (ignore_req) begin
                  rsp_payload_in.status = STATUS_IGNORED;
               end else if (req_ff.mode == MODE_ALLOC && hit_ff) begin
                  // reuse the free block whole
                  mem_we     = 1'b1;
                  mem_wa     = hit_idx_ff[IDX_W-1:0];
                  mem_wd     = hit_entry_ff;
                  mem_wd.is_free = 1'b0;
                  rsp_payload_in.payload_address = 16'(hit_entry_ff.start + 16'(HEADER_BYTES));
               end else if (req_ff.mode == MODE_ALLOC) begin
                  if (entry_count_ff >= CNT_W'(MAX_BLOCKS)) begin
                     rsp_payload_in.status = STATUS_NOMEM;
                  end else if (grow_top > {2'b00, eff_limit}) begin
                     rsp_payload_in.status = STATUS_NOMEM;
                  end else begin
                     // append at the heap top
                     mem_we         = 1'b1;
                     mem_wa         = entry_count_ff[IDX_W-1:0];
                     mem_wd         = '{start: heap_top_ff[15:0],
                                        length: req_ff.request_size,
                                        is_free: 1'b0};
                     entry_count_in = entry_count_ff + CNT_W'(1);
                     heap_top_in    = grow_top[16:0];
                     rsp_payload_in.payload_address =
                        16'(heap_top_ff[15:0] + 16'(HEADER_BYTES));
                  end
               end else if (hit_ff) begin
                  if (hit_end == {1'b0, heap_top_ff}) begin
                     // last block: drop it and lower the top
                     heap_top_in    = {1'b0, hit_entry_ff.start};
                     entry_count_in = hit_idx_ff;
                  end else begin
                     mem_we         = 1'b1;
                     mem_wa         = hit_idx_ff[IDX_W-1:0];
                     mem_wd         = hit_entry_ff;
                     mem_wd.is_free = 1'b1;
                  end
               end else begin
                  rsp_payload_in.status = STATUS_UNKNOWN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         heap_top_ff    <= '0;
         heap_limit_ff  <= 17'd65536;
         rsp_valid_ff   <= 1'b0;
         chk_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         heap_top_ff    <= heap_top_in;
         heap_limit_ff  <= heap_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
         chk_vld_ff     <= chk_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      total_ff       <= total_in;
      issue_idx_ff   <= issue_idx_in;
      chk_idx_ff     <= chk_idx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      hit_entry_ff   <= hit_entry_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // block table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_entry_ff <= entry_mem[issue_idx_ff[IDX_W-1:0]];
   end

   // busy right after a beat is taken
   `FFA_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_fire, !req_ready)
   // the table never holds more than its depth
   `FFA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, entry_count_ff <= CNT_W'(MAX_BLOCKS))
   // the heap top stays within the growth bound
   `FFA_ASSERT_NOW(a_top_bound, clock, reset, 1'b1, heap_top_ff <= 17'(LIMIT_CAP))
   // only a successful allocate carries an address
   `FFA_ASSERT_NOW(a_fail_no_addr, clock, reset,
      rsp_valid_ff && (rsp_payload_ff.status != STATUS_DONE),
      rsp_payload_ff.payload_address == 16'd0)

endmodule

@@ verif/ffa_grant_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the limit register, keeps its own copy of the
// block table, and compares every result beat with the oldest prediction.
module ffa_grant_checker
   import ffa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  ffa_req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  ffa_rsp_type rsp_payload,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   output int          mismatch_count,
   output int          outstanding
);

   localparam int PRINT_CAP = 40;

   logic [15:0] blk_start [MAX_BLOCKS];
   logic [16:0] blk_len   [MAX_BLOCKS];
   bit          blk_free  [MAX_BLOCKS];
   int          blk_count;
   int          top_offset;
   int          limit_reg;

   ffa_rsp_type expected_grants [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ns: ffa check, %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Apply one request to the shadow table and return the result it gives.
   function automatic ffa_rsp_type serve_request(input ffa_req_type r);
      ffa_rsp_type res;
      int          i;
      int          cap;
      int          need;
      int          addr;
      bit          hit;
      res.payload_address = '0;
      res.status          = STATUS_DONE;
      hit                 = 1'b0;
      if (r.mode == MODE_ALLOC) begin
         if (r.request_size == '0) begin
            res.status = STATUS_IGNORED;
         end else begin
            for (i = 0; i < blk_count; i++) begin
               if (!hit && blk_free[i] && blk_len[i] >= r.request_size) begin
                  blk_free[i]         = 1'b0;
                  res.payload_address = 16'(int'(blk_start[i]) + HEADER_BYTES);
                  hit                 = 1'b1;
               end
            end
            if (!hit) begin
               cap  = (limit_reg < LIMIT_CAP) ? limit_reg : LIMIT_CAP;
               need = HEADER_BYTES + int'(r.request_size);
               if (blk_count >= MAX_BLOCKS || top_offset + need > cap) begin
                  res.status = STATUS_NOMEM;
               end else begin
                  blk_start[blk_count] = 16'(top_offset);
                  blk_len[blk_count]   = r.request_size;
                  blk_free[blk_count]  = 1'b0;
                  blk_count++;
                  res.payload_address = 16'(top_offset + HEADER_BYTES);
                  top_offset          = top_offset + need;
               end
            end
         end
      end else begin
         addr = int'(r.release_address);
         if (addr == 0) begin
            res.status = STATUS_IGNORED;
         end else begin
            for (i = 0; i < blk_count; i++) begin
               if (!hit && int'(blk_start[i]) + HEADER_BYTES == addr) begin
                  hit = 1'b1;
                  // a block that ends at the top is dropped, anything else is marked
                  if (int'(blk_start[i]) + HEADER_BYTES + int'(blk_len[i]) == top_offset) begin
                     top_offset = int'(blk_start[i]);
                     blk_count  = i;
                  end else begin
                     blk_free[i] = 1'b1;
                  end
               end
            end
            if (!hit) res.status = STATUS_UNKNOWN;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      ffa_rsp_type want;
      if (reset) begin
         limit_reg  = 65536;
         blk_count  = 0;
         top_offset = 0;
         expected_grants.delete();
      end else begin
         if (csr_wr_en) limit_reg = int'(csr_wr_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               report_mismatch("result beat with nothing pending", int'(rsp_payload), 0);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_payload.payload_address !== want.payload_address)
                  report_mismatch("payload_address", int'(rsp_payload.payload_address),
                                  int'(want.payload_address));
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", int'(rsp_payload.status), int'(want.status));
            end
         end
         if (req_valid && req_ready) expected_grants.push_back(serve_request(req_payload));
      end
      outstanding = expected_grants.size();
   end

endmodule

@@ verif/first_fit_block_allocator_tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the first-fit block allocator. All prediction and
// comparison lives in ffa_grant_checker; this module only drives the block.
module first_fit_block_allocator_tb;
   import ffa_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 5;
   localparam int STALL_LIMIT  = 2000;  // cycles without any beat before giving up
   localparam int LONG_HOLD    = 300;   // receiver hold-off that backs up the block
   localparam int SETTLE       = 4;
   localparam int DRAIN_CYCLES = 80;    // a full table scan plus a few cycles
   localparam int FILL_ITEMS   = 70;
   localparam int PHASE_ITEMS  = 190;
   localparam int NUM_PHASES   = 7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   ffa_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   ffa_rsp_type rsp_payload;
   logic        csr_wr_en;
   logic [16:0] csr_wr_data;

   int          mismatch_count;
   int          outstanding;
   int          idle_cycles;
   bit          quiet;         // no idling on either side
   bit          hold_request;  // ask the receiver for one long hold-off
   logic [15:0] live_addrs [$];
   logic [16:0] phase_limit [NUM_PHASES];

   first_fit_block_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ffa_grant_checker grant_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Collect granted payload addresses so that most frees hit live blocks.
   // Frees answer with address 0, so a nonzero done result is always a grant.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_payload.status == STATUS_DONE &&
          rsp_payload.payload_address != '0)
         live_addrs.push_back(rsp_payload.payload_address);
   end

   // Watchdog: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts of random length, one long hold-off on
   // request, and a steady ready once the run goes quiet.
   initial begin
      int stall_left;
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready    = 1'b0;
            stall_left   = LONG_HOLD - 1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Build an allocate beat; the unused address field carries noise.
   function automatic ffa_req_type alloc_req(input int size);
      ffa_req_type r;
      r.mode            = MODE_ALLOC;
      r.request_size    = 17'(size);
      r.release_address = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   // Build a free beat; the unused size field carries noise.
   function automatic ffa_req_type free_req(input int addr);
      ffa_req_type r;
      r.mode            = MODE_FREE;
      r.request_size    = 17'($urandom_range(0, 65536));
      r.release_address = 16'(addr);
      return r;
   endfunction

   // Mostly small allocations and frees of live blocks, with some zero
   // sizes, huge sizes, null frees and addresses that match no block.
   function automatic ffa_req_type pick_beat(input int alloc_pct);
      int sel;
      int idx;
      int addr;
      sel = $urandom_range(0, 19);
      if ($urandom_range(0, 99) < alloc_pct) begin
         if (sel == 0)      return alloc_req(0);
         else if (sel == 1) return alloc_req($urandom_range(1, 65536));
         else if (sel < 4)  return alloc_req($urandom_range(257, 4096));
         else if (sel < 8)  return alloc_req($urandom_range(1, 4));
         else               return alloc_req($urandom_range(1, 256));
      end
      if (sel < 15 && live_addrs.size() > 0) begin
         idx  = $urandom_range(0, live_addrs.size() - 1);
         addr = int'(live_addrs[idx]);
         // keep some addresses around so they get freed twice
         if (sel < 11) live_addrs.delete(idx);
         return free_req(addr);
      end
      if (sel == 15) return free_req(0);
      if (sel == 16) return free_req(($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(1, 65535));
      if (sel == 17 && live_addrs.size() > 0) begin
         addr = int'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
         return free_req(($urandom_range(0, 1) == 1) ? addr + 1 : addr - 1);
      end
      return free_req($urandom_range(1, 65535));
   endfunction

   // Offer one beat and hold it until the block takes it; maybe idle after.
   task automatic send_beat(input ffa_req_type b);
      req_payload = b;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   // Drop valid and hold off until every pending result has come back.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_limit(input logic [16:0] value);
      wait_idle();
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   initial begin
      int p;
      int n;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Limit right at one header plus one byte: one-byte block fits exactly.
      write_limit(17'd25);
      send_beat(alloc_req(2));
      send_beat(alloc_req(1));
      send_beat(free_req(HEADER_BYTES));

      // Directed: ignored requests, unknown address, exact fill of the heap,
      // reuse without split, repeated free and removal of the last block.
      write_limit(17'd65536);
      send_beat(alloc_req(0));
      send_beat(free_req(0));
      send_beat(free_req(65535));
      send_beat(alloc_req(65536));
      send_beat(alloc_req(65536 - HEADER_BYTES));
      send_beat(free_req(HEADER_BYTES));
      send_beat(free_req(HEADER_BYTES));
      send_beat(alloc_req(100));
      send_beat(alloc_req(50));
      send_beat(alloc_req(200));
      send_beat(free_req(148));
      send_beat(free_req(148));
      send_beat(alloc_req(60));
      send_beat(alloc_req(40));
      send_beat(free_req(HEADER_BYTES));
      send_beat(alloc_req(100));
      send_beat(free_req(446));
      send_beat(free_req(222));
      send_beat(free_req(149));

      // Zero limit: no growth at all, frees still work.
      write_limit(17'd0);
      send_beat(alloc_req(1));
      send_beat(free_req(148));

      // Limit beyond the address space acts as a full 64 KiB heap.
      write_limit(17'd131071);
      send_beat(alloc_req(65536));
      send_beat(alloc_req(65536 - 124 - HEADER_BYTES));

      // Drop the big block at the top, then fill the table with small
      // blocks until it reports full.
      write_limit(17'd65536);
      send_beat(free_req(148));
      for (n = 0; n < FILL_ITEMS; n++) send_beat(alloc_req($urandom_range(1, 64)));

      // Drain from the top down so the heap top keeps dropping.
      wait_idle();
      while (live_addrs.size() > 0) send_beat(free_req(int'(live_addrs.pop_back())));

      phase_limit = '{17'd25, 17'd24, 17'd4096, 17'd131071,
                      17'($urandom_range(0, 131071)), 17'd1000, 17'd65536};
      for (p = 0; p < NUM_PHASES; p++) begin
         write_limit(phase_limit[p]);
         if (p == NUM_PHASES - 1) quiet = 1'b1;
         // long receiver hold while the sender keeps offering beats
         if (p == 1) hold_request = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // pause the sender until every pending result has arrived
            if (p == 3 && n == PHASE_ITEMS / 2) wait_idle();
            send_beat(pick_beat((p == 0) ? 70 : 55));
         end
      end

      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
